// ----- design/arb_pkg.sv -----
package arb_pkg;

  // Bank geometry
  localparam int NUM_REGS = 256;
  localparam int ADDR_W   = $clog2(NUM_REGS);
  localparam int WORD_W   = 16;
  localparam int DATA_W   = 2 * WORD_W;
  localparam int SIZE_W   = ADDR_W + 1;
  localparam int CNT_W    = $clog2(DATA_W);

  // Configuration register indexes
  localparam logic CFG_BANK_SIZE = 1'b0;
  localparam logic CFG_BACKING   = 1'b1;

  localparam logic [SIZE_W-1:0] BANK_SIZE_RST = SIZE_W'(NUM_REGS);

  typedef enum logic [1:0] {
    FN_READ  = 2'd0,
    FN_WRITE = 2'd1,
    FN_APPLY = 2'd2,
    FN_POLL  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    OP_ASSIGN = 4'd0,
    OP_INC    = 4'd1,
    OP_DEC    = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_MUL    = 4'd5,
    OP_DIV    = 4'd6,
    OP_MOD    = 4'd7,
    OP_AND    = 4'd8,
    OP_OR     = 4'd9,
    OP_XOR    = 4'd10,
    OP_SHL    = 4'd11,
    OP_SHR    = 4'd12
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_EXEC,
    ST_DIV,
    ST_WR_LO,
    ST_WR_HI
  } state_t;

  // Handshake between the sequencer and the divider
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
  } div_res_t;

endpackage

// ----- design/arb_div.sv -----
module arb_div
  import arb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_res_t          res
);

  // Restoring divider, one quotient bit per cycle
  logic              run;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvsr;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign rem_sh = {rem, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(DATA_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
      cnt  <= '0;
    end else if (run) begin
      cnt <= cnt + CNT_W'(1);
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign res.done = done;
  assign res.quo  = quo;
  assign res.rem  = rem;

endmodule

// ----- design/atomic_register_bank_rmw.sv -----
// Atomic register bank: 256 words of 16 bits with read, write and
// read-modify-write, on one word or on a little-endian pair.
//
// Command channel: an item is taken when start is high and busy is low.
// Result channel: done is high for exactly one cycle with read_data,
// in_range and save_flag; the receiver cannot hold it off, so the block
// never stalls on the output side.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 bank_size,
// 1 backing_present) at once; the user writes only while idle (not enforced).
//
// States per item (one sequencer, one memory port for reads and one for writes,
// so one item at a time):
//   poll, or access out of range : done without leaving ST_IDLE
//   read                         : ST_LO, ST_HI if wide, ST_EXEC
//   write / apply                : as read, then ST_WR_LO, ST_WR_HI if wide
//   apply divide / modulo        : adds ST_DIV for the bit-serial divider (nonzero divisor)
// Worst case is a wide divide; busy stays high meanwhile.
//
// Reset clears the save flag, sets bank_size to 256 and backing_present to 1;
// per-entry valid bits cleared by reset make the bank read as zero at once.
module atomic_register_bank_rmw
  import arb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func,
  input  logic [3:0]        op,
  input  logic              wide,
  input  logic [ADDR_W-1:0] word_index,
  input  logic [DATA_W-1:0] operand,
  output logic              done,
  output logic [DATA_W-1:0] read_data,
  output logic              in_range,
  output logic              save_flag,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [SIZE_W-1:0] bank_size;
  logic              backing;
  logic              save_pending;

  // Latched command
  logic [1:0]        func_r;
  logic [3:0]        op_r;
  logic              wide_r;
  logic [ADDR_W-1:0] idx_r;
  logic [DATA_W-1:0] opnd_r;

  logic [DATA_W-1:0] cur;   // value before the update
  logic [DATA_W-1:0] res;   // value to store

  // Word store, one read and one write port, registered read
  logic [WORD_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  logic [WORD_W-1:0]   mem_q;
  logic                vld_q;
  logic [WORD_W-1:0]   rd_word;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic              accept;
  logic              fit_in;
  logic [SIZE_W-1:0] size_sat;
  logic [SIZE_W:0]   end_in;
  logic [DATA_W-1:0] mask_in;

  logic              is_div;
  logic              div_start;
  logic              fin_rd;
  logic              fin_wr;
  div_res_t          div_res;

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] prod;
  logic              sh_big;
  logic [CNT_W-1:0]  shamt;
  logic [DATA_W-1:0] alu;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Range test: index + width must not pass the saturated bank size
  assign size_sat = (bank_size > BANK_SIZE_RST) ? BANK_SIZE_RST : bank_size;
  assign end_in   = {2'b00, word_index} + (wide ? (SIZE_W+1)'(2) : (SIZE_W+1)'(1));
  assign fit_in   = (end_in <= {1'b0, size_sat});
  assign mask_in  = wide ? '1 : {{WORD_W{1'b0}}, {WORD_W{1'b1}}};

  assign rd_word = vld_q ? mem_q : '0;

  // ALU on the latched operands
  assign mask   = wide_r ? '1 : {{WORD_W{1'b0}}, {WORD_W{1'b1}}};
  assign prod   = cur * opnd_r;
  assign sh_big = wide_r ? (opnd_r[DATA_W-1:CNT_W] != '0)
                         : (opnd_r[DATA_W-1:CNT_W-1] != '0);
  assign shamt  = opnd_r[CNT_W-1:0];
  assign is_div = (func_r == FN_APPLY) && (op_r == OP_DIV || op_r == OP_MOD)
                  && (opnd_r != '0);

  always_comb begin
    alu = cur;
    if (func_r == FN_WRITE) begin
      alu = opnd_r;
    end else begin
      case (op_r)
        OP_ASSIGN: alu = opnd_r;
        OP_INC:    alu = (cur + DATA_W'(1)) & mask;
        OP_DEC:    alu = (cur - DATA_W'(1)) & mask;
        OP_ADD:    alu = (cur + opnd_r) & mask;
        OP_SUB:    alu = (cur - opnd_r) & mask;
        OP_MUL:    alu = prod & mask;
        OP_AND:    alu = cur & opnd_r;
        OP_OR:     alu = cur | opnd_r;
        OP_XOR:    alu = cur ^ opnd_r;
        OP_SHL:    alu = sh_big ? '0 : ((cur << shamt) & mask);
        OP_SHR:    alu = sh_big ? '0 : (cur >> shamt);
        default:   alu = cur;  // divide by zero and unused codes keep it
      endcase
    end
  end

  arb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur),
    .divisor  (opnd_r),
    .res      (div_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && func != FN_POLL && fit_in) state_next = ST_LO;
      end
      ST_LO:   state_next = wide_r ? ST_HI : ST_EXEC;
      ST_HI:   state_next = ST_EXEC;
      ST_EXEC: begin
        if (func_r == FN_READ) state_next = ST_IDLE;
        else if (is_div)       state_next = ST_DIV;
        else                   state_next = ST_WR_LO;
      end
      ST_DIV: begin
        if (div_res.done) state_next = ST_WR_LO;
      end
      ST_WR_LO: state_next = wide_r ? ST_WR_HI : ST_IDLE;
      ST_WR_HI: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mem_raddr = idx_r + ADDR_W'(1);
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = res[WORD_W-1:0];
    div_start = 1'b0;
    fin_rd    = 1'b0;
    fin_wr    = 1'b0;
    case (state)
      ST_IDLE: mem_raddr = word_index;
      ST_EXEC: begin
        fin_rd    = (func_r == FN_READ);
        div_start = (func_r != FN_READ) && is_div;
      end
      ST_WR_LO: begin
        mem_we = 1'b1;
        fin_wr = !wide_r;
      end
      ST_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + ADDR_W'(1);
        mem_wdata = res[DATA_W-1:WORD_W];
        fin_wr    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (mem_we) vld[mem_waddr] <= 1'b1;
      vld_q <= vld[mem_raddr];
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      save_pending <= 1'b0;
      bank_size    <= BANK_SIZE_RST;
      backing      <= 1'b1;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BANK_SIZE: bank_size <= cfg_data;
          CFG_BACKING:   backing   <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && (func == FN_POLL || !fit_in)) begin
        done <= 1'b1;
        if (func == FN_POLL) save_pending <= 1'b0;
      end
      if (fin_rd) done <= 1'b1;
      if (fin_wr) begin
        done         <= 1'b1;
        save_pending <= save_pending | backing;
      end
    end
  end

  // Payload: latched command, working values and the result transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= func;
      op_r      <= op;
      wide_r    <= wide;
      idx_r     <= word_index;
      opnd_r    <= operand & mask_in;
      read_data <= '0;
      in_range  <= 1'b0;
      save_flag <= save_pending;
    end
    case (state)
      ST_LO:   cur <= {{WORD_W{1'b0}}, rd_word};
      ST_HI:   cur[DATA_W-1:WORD_W] <= rd_word;
      ST_EXEC: res <= alu;
      ST_DIV: begin
        if (div_res.done) res <= (op_r == OP_MOD) ? div_res.rem : div_res.quo;
      end
      default: ;
    endcase
    if (fin_rd) begin
      read_data <= cur;
      in_range  <= 1'b1;
      save_flag <= save_pending;
    end
    if (fin_wr) begin
      read_data <= cur;
      in_range  <= 1'b1;
      save_flag <= save_pending | backing;
    end
  end

endmodule
